### rtl/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_HOLD(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/mmms_pkg.sv
// shared types and constants for the min/max multiset spread block
// no dependencies
package mmms_pkg;

	localparam int AMT_W = 32;
	localparam int SUM_W = 64;
	localparam int HC_W  = 9;
	localparam int ACT_W = 2;
	localparam int GRP   = 16;

	localparam logic [ACT_W-1:0] ACT_INSERT  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_DAY_END = 2'd1;
	localparam logic [ACT_W-1:0] ACT_FINISH  = 2'd2;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_SHIFT
	} cell_op_t;

	typedef struct packed {
		cell_op_t           op;
		logic [AMT_W-1:0]   amount;
	} cell_ctl_t;

endpackage

### rtl/min_max_multiset_spread.sv
// min/max multiset spread: double-ended priority queue over a sorted chain of cells
// depends on mmms_pkg and mmms_cell
//
// usage:
//  input channel (in_valid/in_stall) carries one word: action and amount.
//  action insert adds amount, end of day removes smallest and largest,
//  finish reports the running sum and clears store and sum.
//  output channel (out_valid/out_stall) carries exactly one result word per
//  input word, held in an output register.
//  insert, finish and the unused code put their result in the output register
//  when accepted; end of day on a non-empty store first goes through the
//  registered largest-value gather over 16-cell groups and the pick state.
//  throughput: one insert or finish per cycle unless a result is stalled.
//  the input stalls while an end of day is in progress and while a result
//  waits under out_stall; a stalled result holds its value.
//  reset clears the count, the sum and the output valid; cell contents are
//  left as they are and are only read below the count.
module min_max_multiset_spread #(
	parameter int CAPACITY = 256
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [mmms_pkg::ACT_W-1:0] action,
	input  logic [mmms_pkg::AMT_W-1:0] amount,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [mmms_pkg::AMT_W-1:0] day_min,
	output logic [mmms_pkg::AMT_W-1:0] day_max,
	output logic [mmms_pkg::SUM_W-1:0] running_sum,
	output logic                      store_full,
	output logic                      store_empty,
	output logic [mmms_pkg::HC_W-1:0]  held_count
);
	import mmms_pkg::*;

	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int NGRP = (CAPACITY + GRP - 1) / GRP;

	typedef enum logic {
		ST_IDLE,
		ST_PICK
	} state_t;

	state_t              state_q;
	logic [CW-1:0]       count_q;
	logic [SUM_W-1:0]    sum_q;
	logic                out_valid_q;
	logic [AMT_W-1:0]    day_min_q;
	logic [AMT_W-1:0]    day_max_q;
	logic [SUM_W-1:0]    running_sum_q;
	logic                store_full_q;
	logic                store_empty_q;
	logic [HC_W-1:0]     held_count_q;

	logic                accept;
	logic                is_full;
	cell_ctl_t           ctl;
	logic [AMT_W-1:0]    cell_val [CAPACITY];
	logic                cell_gt  [CAPACITY];
	logic                cell_tail [CAPACITY];
	logic [AMT_W-1:0]    grp_d  [NGRP];
	logic [AMT_W-1:0]    grp_s1 [NGRP];
	logic [AMT_W-1:0]    hi_pick;
	logic [AMT_W-1:0]    diff;
	logic [CW-1:0]       cnt_after_day;

	// handshake
	assign in_stall = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign accept   = in_valid && !in_stall;
	assign is_full  = count_q == CW'(CAPACITY);

	// chain control
	always_comb begin
		ctl.amount = amount;
		if (state_q == ST_PICK) begin
			ctl.op = CELL_SHIFT;
		end else if (accept && action == ACT_INSERT && !is_full) begin
			ctl.op = CELL_INSERT;
		end else begin
			ctl.op = CELL_HOLD;
		end
	end

	// the chain of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [AMT_W-1:0] lv;
		logic             lg;
		logic [AMT_W-1:0] rv;
		if (i == 0) begin : g_first
			assign lv = '0;
			assign lg = 1'b0;
		end else begin : g_mid
			assign lv = cell_val[i-1];
			assign lg = cell_gt[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign rv = cell_val[i];
		end else begin : g_inner
			assign rv = cell_val[i+1];
		end
		assign cell_tail[i] = count_q == CW'(i + 1);
		mmms_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.occupied  (CW'(i) < count_q),
			.at_tail   (count_q == CW'(i)),
			.left_val  (lv),
			.left_gt   (lg),
			.right_val (rv),
			.val       (cell_val[i]),
			.gt        (cell_gt[i])
		);
	end

	// largest amount: or of the tail cell within each group of 16
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_d[g] = '0;
			for (int j = 0; j < GRP; j++) begin
				if (g * GRP + j < CAPACITY) begin
					if (cell_tail[g * GRP + j]) begin
						grp_d[g] = grp_d[g] | cell_val[g * GRP + j];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		grp_s1 <= grp_d;
	end

	// combine the group results
	always_comb begin
		hi_pick = '0;
		for (int g = 0; g < NGRP; g++) begin
			hi_pick = hi_pick | grp_s1[g];
		end
	end

	assign diff          = hi_pick - cell_val[0];
	assign cnt_after_day = (count_q == CW'(1)) ? '0 : count_q - CW'(2);

	// sequencer, state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			count_q       <= '0;
			sum_q         <= '0;
			out_valid_q   <= 1'b0;
			day_min_q     <= '0;
			day_max_q     <= '0;
			running_sum_q <= '0;
			store_full_q  <= 1'b0;
			store_empty_q <= 1'b0;
			held_count_q  <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						day_min_q     <= '0;
						day_max_q     <= '0;
						store_full_q  <= 1'b0;
						store_empty_q <= 1'b0;
						running_sum_q <= sum_q;
						held_count_q  <= HC_W'(count_q);
						case (action)
							ACT_INSERT: begin
								out_valid_q  <= 1'b1;
								store_full_q <= is_full;
								if (!is_full) begin
									count_q      <= count_q + CW'(1);
									held_count_q <= HC_W'(count_q + CW'(1));
								end
							end
							ACT_DAY_END: begin
								if (count_q == '0) begin
									out_valid_q   <= 1'b1;
									store_empty_q <= 1'b1;
								end else begin
									state_q <= ST_PICK;
								end
							end
							ACT_FINISH: begin
								out_valid_q  <= 1'b1;
								count_q      <= '0;
								sum_q        <= '0;
								held_count_q <= '0;
							end
							default: begin
								out_valid_q <= 1'b1;
							end
						endcase
					end
				end
				ST_PICK: begin
					out_valid_q   <= 1'b1;
					day_min_q     <= cell_val[0];
					day_max_q     <= hi_pick;
					sum_q         <= sum_q + SUM_W'(diff);
					running_sum_q <= sum_q + SUM_W'(diff);
					count_q       <= cnt_after_day;
					held_count_q  <= HC_W'(cnt_after_day);
					state_q       <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign day_min     = day_min_q;
	assign day_max     = day_max_q;
	assign running_sum = running_sum_q;
	assign store_full  = store_full_q;
	assign store_empty = store_empty_q;
	assign held_count  = held_count_q;

endmodule

### rtl/mmms_cell.sv
// one cell of the sorted chain: holds one amount and moves it to keep order
// depends on mmms_pkg
module mmms_cell (
	input  logic                    clk,
	input  mmms_pkg::cell_ctl_t     ctl,
	input  logic                    occupied,
	input  logic                    at_tail,
	input  logic [31:0]             left_val,
	input  logic                    left_gt,
	input  logic [31:0]             right_val,
	output logic [31:0]             val,
	output logic                    gt
);
	import mmms_pkg::*;

	logic [AMT_W-1:0] val_q;
	logic             take;

	// compare against the incoming amount; only meaningful when occupied
	assign gt  = val_q > ctl.amount;
	assign val = val_q;

	// this cell changes when the new amount lands here or to its left
	assign take = occupied ? gt : at_tail;

	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_INSERT: begin
				if (take) begin
					val_q <= left_gt ? left_val : ctl.amount;
				end
			end
			CELL_SHIFT: begin
				val_q <= right_val;
			end
			default: begin
			end
		endcase
	end

endmodule

### rtl/mmms_checker.sv
// port-level checks for the min/max multiset spread block, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module mmms_checker #(
	parameter int CAPACITY = 256
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] day_min,
	input logic [31:0] day_max,
	input logic [63:0] running_sum,
	input logic        store_full,
	input logic        store_empty,
	input logic [8:0]  held_count
);

	logic         out_wait;
	logic [104:0] result_word;
	logic         empty_clean;
	logic         at_capacity;

	// terms shared by the checks below
	assign out_wait    = out_valid && out_stall;
	assign result_word = {running_sum, held_count, day_max};
	assign empty_clean = day_min == 32'd0 && day_max == 32'd0 && held_count == 9'd0
		&& !store_full;
	assign at_capacity = held_count == 9'(CAPACITY);

	// a waiting result must block new words
	`ASSERT_HOLD(a_stall_blocks_in, clk, arst_n, out_wait, in_stall, "input taken while stalled")

	// a stalled result stays valid and holds its sum, count and largest amount
	`ASSERT_NEXT(a_result_holds, clk, arst_n, out_wait, out_valid && $stable(result_word), "result changed")

	// empty end of day reports nothing and holds nothing
	`ASSERT_HOLD(a_empty_clean, clk, arst_n, out_valid && store_empty, empty_clean, "bad empty result")

	// removed amounts are ordered
	`ASSERT_HOLD(a_min_le_max, clk, arst_n, out_valid, day_max >= day_min, "day_max below day_min")

	// a dropped insert means the store is at capacity
	`ASSERT_HOLD(a_full_count, clk, arst_n, out_valid && store_full, at_capacity, "full, wrong count")

endmodule

bind min_max_multiset_spread mmms_checker #(.CAPACITY(CAPACITY)) u_mmms_checker (.*);

### tb/tb.sv
// self-checking testbench for min_max_multiset_spread
// depends on mmms_pkg and the block's rtl; predicts every result word with a
// sorted queue model and checks it field by field
`timescale 1ns / 1ps

module tb;
	import mmms_pkg::*;

	localparam int STORE_DEPTH = 256;
	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 4000;
	localparam int TAIL_CYCLES = 16;
	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

	typedef struct {
		logic [ACT_W-1:0] act;
		logic [AMT_W-1:0] amt;
		int               phase;
		bit               wait_drain;
		bit               hold_out;
	} stim_word_t;

	typedef struct {
		logic [AMT_W-1:0] lo;
		logic [AMT_W-1:0] hi;
		logic [SUM_W-1:0] sum;
		logic             full;
		logic             empty;
		logic [HC_W-1:0]  count;
	} spread_result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [ACT_W-1:0] action = ACT_INSERT;
	logic [AMT_W-1:0] amount = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [AMT_W-1:0] day_min;
	logic [AMT_W-1:0] day_max;
	logic [SUM_W-1:0] running_sum;
	logic             store_full;
	logic             store_empty;
	logic [HC_W-1:0]  held_count;

	// idle percentages per phase: none, sender, receiver, both
	int unsigned send_idle_pct [4] = '{0, 61, 0, 23};
	int unsigned recv_stall_pct [4] = '{0, 0, 61, 23};

	stim_word_t       pending_words [$];
	stim_word_t       offered;
	spread_result_t   expected_results [$];
	spread_result_t   oldest;
	logic [AMT_W-1:0] held_amounts [$];
	logic [SUM_W-1:0] held_sum = '0;
	int unsigned      stall_pct = 0;
	logic             hold_req = 1'b0;
	int               hold_left = 0;
	int               quiet_cycles = 0;
	int               failures = 0;

	min_max_multiset_spread #(
		.CAPACITY(STORE_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.amount(amount),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.day_min(day_min),
		.day_max(day_max),
		.running_sum(running_sum),
		.store_full(store_full),
		.store_empty(store_empty),
		.held_count(held_count)
	);

	always #2 clk = ~clk;

	// prediction: ascending queue of held amounts and the spread sum
	function automatic spread_result_t apply_word(stim_word_t w);
		spread_result_t   r;
		int               pos;
		logic [SUM_W-1:0] total;
		r = '{default: '0};
		total = held_sum;
		case (w.act)
		ACT_INSERT: begin
			if (held_amounts.size() >= STORE_DEPTH) begin
				r.full = 1'b1;
			end else begin
				pos = 0;
				while (pos < held_amounts.size() && held_amounts[pos] <= w.amt)
					pos++;
				held_amounts.insert(pos, w.amt);
			end
		end
		ACT_DAY_END: begin
			if (held_amounts.size() == 0) begin
				r.empty = 1'b1;
			end else begin
				r.lo = held_amounts[0];
				r.hi = held_amounts[$];
				void'(held_amounts.pop_front());
				if (held_amounts.size() != 0)
					void'(held_amounts.pop_back());
				held_sum += SUM_W'(r.hi - r.lo);
			end
		end
		ACT_FINISH: begin
			held_amounts.delete();
			held_sum = '0;
		end
		default: begin
		end
		endcase
		r.sum = (w.act == ACT_FINISH) ? total : held_sum;
		r.count = HC_W'(held_amounts.size());
		return r;
	endfunction

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			failures++;
		end
	endfunction

	// amounts: extremes, small values for duplicates, wide random
	function automatic logic [AMT_W-1:0] pick_amount();
		case ($urandom_range(9))
		0: return '0;
		1: return '1;
		2, 3, 4: return AMT_W'($urandom_range(15));
		5, 6: return AMT_W'($urandom_range(1000));
		default: return AMT_W'($urandom);
		endcase
	endfunction

	task automatic queue_word(input logic [ACT_W-1:0] act, input logic [AMT_W-1:0] amt,
			input int phase, input bit drain = 1'b0, input bit hold = 1'b0);
		stim_word_t w;
		w.act = act;
		w.amt = amt;
		w.phase = phase;
		w.wait_drain = drain;
		w.hold_out = hold;
		pending_words.push_back(w);
	endtask

	// fill past capacity, free two slots, refill until dropped again, clear
	task automatic queue_fill(input int phase);
		repeat (STORE_DEPTH + 2)
			queue_word(ACT_INSERT, pick_amount(), phase);
		queue_word(ACT_DAY_END, pick_amount(), phase);
		repeat (3)
			queue_word(ACT_INSERT, pick_amount(), phase);
		queue_word(ACT_FINISH, pick_amount(), phase);
	endtask

	// mostly days of inserts then extractions, some finishes and noise
	task automatic queue_random(input int phase, input int n);
		int made;
		int k;
		int day_ends;
		int kind;
		made = 0;
		while (made < n) begin
			kind = $urandom_range(99);
			if (kind < 72) begin
				k = $urandom_range(1, 8);
				day_ends = $urandom_range(1, k / 2 + 1);
				repeat (k)
					queue_word(ACT_INSERT, pick_amount(), phase);
				repeat (day_ends)
					queue_word(ACT_DAY_END, AMT_W'($urandom), phase);
				made += k + day_ends;
			end else if (kind < 80) begin
				queue_word(ACT_FINISH, AMT_W'($urandom), phase);
				made++;
			end else begin
				queue_word(ACT_W'($urandom_range(3)), AMT_W'($urandom), phase);
				made++;
			end
		end
	endtask

	// driver: predicts each accepted word, offers the next pending one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			hold_req <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				expected_results.push_back(apply_word(offered));
			if (in_valid && in_stall) begin
				hold_req <= 1'b0;
			end else if (pending_words.size() != 0
					&& !(pending_words[0].wait_drain && expected_results.size() != 0)
					&& $urandom_range(99) >= send_idle_pct[pending_words[0].phase]) begin
				offered = pending_words.pop_front();
				in_valid <= 1'b1;
				action <= offered.act;
				amount <= offered.amt;
				hold_req <= offered.hold_out;
				stall_pct <= recv_stall_pct[offered.phase];
			end else begin
				in_valid <= 1'b0;
				hold_req <= 1'b0;
			end
		end
	end

	// receiver stall: long hold-off on request, else random per phase
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
		end else begin
			if (hold_req)
				hold_left <= HOLD_CYCLES;
			else if (hold_left != 0)
				hold_left <= hold_left - 1;
			out_stall <= hold_req || hold_left != 0 || $urandom_range(99) < stall_pct;
		end
	end

	// monitor: compare each accepted result word with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("result word with no prediction pending");
				failures++;
			end else begin
				oldest = expected_results.pop_front();
				check_field("day_min", 64'(oldest.lo), 64'(day_min));
				check_field("day_max", 64'(oldest.hi), 64'(day_max));
				check_field("running_sum", oldest.sum, running_sum);
				check_field("store_full", 64'(oldest.full), 64'(store_full));
				check_field("store_empty", 64'(oldest.empty), 64'(store_empty));
				check_field("held_count", 64'(oldest.count), 64'(held_count));
			end
		end
	end

	// watchdog on cycles with no word moving on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$error("no progress for %0d cycles", QUIET_LIMIT);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin
		// directed: empty store, extremes, duplicates, single item, unused code
		queue_word(ACT_DAY_END, '0, 0);
		queue_word(ACT_UNUSED, '1, 0);
		queue_word(ACT_FINISH, '0, 0);
		queue_word(ACT_INSERT, '1, 0);
		queue_word(ACT_INSERT, '0, 0);
		queue_word(ACT_INSERT, 32'd5, 0);
		queue_word(ACT_INSERT, 32'd5, 0);
		queue_word(ACT_DAY_END, '0, 0);
		queue_word(ACT_DAY_END, '1, 0);
		queue_word(ACT_INSERT, 32'h8000_0000, 0);
		queue_word(ACT_DAY_END, '0, 0);
		queue_word(ACT_DAY_END, '0, 0);
		queue_word(ACT_INSERT, 32'hAAAA_AAAA, 0);
		queue_word(ACT_INSERT, 32'h5555_5555, 0);
		queue_word(ACT_INSERT, '1, 0);
		queue_word(ACT_UNUSED, 32'h5555_5555, 0);
		queue_word(ACT_DAY_END, '0, 0);
		queue_word(ACT_FINISH, '1, 0);
		queue_word(ACT_DAY_END, '0, 0);
		queue_word(ACT_FINISH, '0, 0);

		// phase 0: long receiver hold-off, then a fill past capacity
		queue_word(ACT_INSERT, pick_amount(), 0, 1'b1, 1'b1);
		queue_fill(0);
		queue_random(0, 250);
		// sender idles
		queue_word(ACT_INSERT, pick_amount(), 1, 1'b1);
		queue_random(1, 350);
		// receiver stalls
		queue_word(ACT_INSERT, pick_amount(), 2, 1'b1);
		queue_random(2, 350);
		// both idle
		queue_word(ACT_INSERT, pick_amount(), 3, 1'b1);
		queue_fill(3);
		queue_random(3, 250);

		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_words.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (failures == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
